// ===== sv/hrhp_pkg.sv =====
package hrhp_pkg;

  localparam int VERSION_BITS_DEF = 8;

  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_SLASH = 8'h2f;
  localparam logic [7:0] CH_DOT   = 8'h2e;
  localparam logic [7:0] CH_COLON = 8'h3a;
  localparam logic [7:0] CH_DEL   = 8'h7f;
  localparam logic [7:0] CH_CTL_MAX = 8'h1f;

  typedef enum logic [4:0] {
    ST_METHOD_START = 5'd0,
    ST_METHOD       = 5'd1,
    ST_URI          = 5'd2,
    ST_VER_H        = 5'd3,
    ST_VER_T1       = 5'd4,
    ST_VER_T2       = 5'd5,
    ST_VER_P        = 5'd6,
    ST_VER_SLASH    = 5'd7,
    ST_MAJOR_START  = 5'd8,
    ST_MAJOR        = 5'd9,
    ST_MINOR_START  = 5'd10,
    ST_MINOR        = 5'd11,
    ST_NL1          = 5'd12,
    ST_LINE_START   = 5'd13,
    ST_LWS          = 5'd14,
    ST_NAME         = 5'd15,
    ST_SPACE_BEFORE = 5'd16,
    ST_VALUE        = 5'd17,
    ST_NL2          = 5'd18,
    ST_NL3          = 5'd19
  } parse_state_t;

  typedef enum logic [1:0] {
    RES_MORE = 2'd0,
    RES_GOOD = 2'd1,
    RES_BAD  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    TAG_NONE   = 3'd0,
    TAG_METHOD = 3'd1,
    TAG_URI    = 3'd2,
    TAG_NAME   = 3'd3,
    TAG_VALUE  = 3'd4
  } byte_tag_t;

  localparam logic CMD_CONSUME = 1'b0;
  localparam logic CMD_RESTART = 1'b1;

  function automatic logic is_ctl(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  function automatic logic is_separator(input logic [7:0] c);
    logic hit;
    unique case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, 8'h3a, 8'h5c, 8'h22,
      8'h2f, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, 8'h20, 8'h09: hit = 1'b1;
      default: hit = 1'b0;
    endcase
    return hit;
  endfunction

  function automatic logic is_token(input logic [7:0] c);
    return !c[7] && !is_ctl(c) && !is_separator(c);
  endfunction

  function automatic logic is_dec_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

// ===== sv/http_request_header_parser.sv =====
// An accepted input item passes the input stage register and then the output
// register to its result item on out_*. Throughput: one item per cycle unless
// out_tready stalls the output; the parse step is one state decode between the
// two registers, with state updated as the item leaves the stage.
// Reset (rst_n low, synchronous): stage and output empty, parser in method start,
// no header seen, version counts zero.
module http_request_header_parser #(
  parameter int VERSION_BITS = hrhp_pkg::VERSION_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [31:0] out_tdata,  // [1:0] status, [9:2] byte_out,
                                  // [17:10] version_major, [25:18] version_minor
  output logic [3:0]  out_tuser   // [2:0] byte_tag, [3] new_header
);
  import hrhp_pkg::*;

  localparam int VB   = VERSION_BITS;
  localparam int WIDE = (VB > 8) ? VB : 8;
  localparam logic [VB-1:0] VMAX = {VB{1'b1}};

  // decimal accumulate with saturation: v*10 + digit
  function automatic logic [VB-1:0] acc_digit(input logic [VB-1:0] v,
                                               input logic [7:0] c);
    logic [VB+3:0] prod;
    prod = ((VB+4)'(v) << 3) + ((VB+4)'(v) << 1) + (VB+4)'(c[3:0]);
    return (prod[VB+3:VB] != 4'd0) ? VMAX : prod[VB-1:0];
  endfunction

  // input stage
  logic       stg_valid_r;
  logic [7:0] stg_byte_r;
  logic       stg_cmd_r;

  // parser state
  parse_state_t    state_r, state_nxt;
  logic            seen_r, seen_nxt;
  logic [VB-1:0]   major_r, major_nxt;
  logic [VB-1:0]   minor_r, minor_nxt;

  // output register
  logic            out_valid_r;
  status_t         res_status_r, res_status_nxt;
  byte_tag_t       res_tag_r, res_tag_nxt;
  logic            res_nh_r, res_nh_nxt;
  logic [7:0]      res_byte_r, res_byte_nxt;

  logic            advance;
  logic [WIDE-1:0] major_wide, minor_wide;

  assign advance   = stg_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !stg_valid_r || advance;

  always_comb begin
    status_t      st;
    byte_tag_t    tag;
    logic         nh;
    parse_state_t ns;
    logic [VB-1:0] nmaj, nmin;
    logic         nseen;
    logic [7:0]   c;

    c     = stg_byte_r;
    st    = RES_MORE;
    tag   = TAG_NONE;
    nh    = 1'b0;
    ns    = state_r;
    nmaj  = major_r;
    nmin  = minor_r;
    nseen = seen_r;

    unique case (state_r)
      ST_METHOD_START: begin
        if (is_token(c)) begin ns = ST_METHOD; tag = TAG_METHOD; end
        else st = RES_BAD;
      end
      ST_METHOD: begin
        if (c == CH_SP) ns = ST_URI;
        else if (is_token(c)) tag = TAG_METHOD;
        else st = RES_BAD;
      end
      ST_URI: begin
        if (c == CH_SP) ns = ST_VER_H;
        else if (is_ctl(c)) st = RES_BAD;
        else tag = TAG_URI;
      end
      ST_VER_H: begin
        if (c == CH_H) ns = ST_VER_T1; else st = RES_BAD;
      end
      ST_VER_T1: begin
        if (c == CH_T) ns = ST_VER_T2; else st = RES_BAD;
      end
      ST_VER_T2: begin
        if (c == CH_T) ns = ST_VER_P; else st = RES_BAD;
      end
      ST_VER_P: begin
        if (c == CH_P) ns = ST_VER_SLASH; else st = RES_BAD;
      end
      ST_VER_SLASH: begin
        if (c == CH_SLASH) begin
          nmaj = '0;
          nmin = '0;
          ns   = ST_MAJOR_START;
        end else st = RES_BAD;
      end
      ST_MAJOR_START: begin
        if (is_dec_digit(c)) begin nmaj = acc_digit(major_r, c); ns = ST_MAJOR; end
        else st = RES_BAD;
      end
      ST_MAJOR: begin
        if (c == CH_DOT) ns = ST_MINOR_START;
        else if (is_dec_digit(c)) nmaj = acc_digit(major_r, c);
        else st = RES_BAD;
      end
      ST_MINOR_START: begin
        if (is_dec_digit(c)) begin nmin = acc_digit(minor_r, c); ns = ST_MINOR; end
        else st = RES_BAD;
      end
      ST_MINOR: begin
        if (c == CH_CR) ns = ST_NL1;
        else if (is_dec_digit(c)) nmin = acc_digit(minor_r, c);
        else st = RES_BAD;
      end
      ST_NL1: begin
        if (c == CH_LF) ns = ST_LINE_START; else st = RES_BAD;
      end
      ST_LINE_START: begin
        // leading whitespace continues the previous header only
        if (c == CH_CR) ns = ST_NL3;
        else if (seen_r && (c == CH_SP || c == CH_TAB)) ns = ST_LWS;
        else if (is_token(c)) begin
          nseen = 1'b1;
          nh    = 1'b1;
          tag   = TAG_NAME;
          ns    = ST_NAME;
        end else st = RES_BAD;
      end
      ST_LWS: begin
        if (c == CH_CR) ns = ST_NL2;
        else if (c == CH_SP || c == CH_TAB) ns = ST_LWS;
        else if (is_ctl(c)) st = RES_BAD;
        else begin ns = ST_VALUE; tag = TAG_VALUE; end
      end
      ST_NAME: begin
        if (c == CH_COLON) ns = ST_SPACE_BEFORE;
        else if (is_token(c)) tag = TAG_NAME;
        else st = RES_BAD;
      end
      ST_SPACE_BEFORE: begin
        if (c == CH_SP) ns = ST_VALUE; else st = RES_BAD;
      end
      ST_VALUE: begin
        if (c == CH_CR) ns = ST_NL2;
        else if (is_ctl(c)) st = RES_BAD;
        else tag = TAG_VALUE;
      end
      ST_NL2: begin
        if (c == CH_LF) ns = ST_LINE_START; else st = RES_BAD;
      end
      ST_NL3: begin
        st = (c == CH_LF) ? RES_GOOD : RES_BAD;
      end
      default: st = RES_BAD;
    endcase

    if (stg_cmd_r == CMD_RESTART) begin
      state_nxt      = ST_METHOD_START;
      seen_nxt       = 1'b0;
      major_nxt      = '0;
      minor_nxt      = '0;
      res_status_nxt = RES_MORE;
      res_tag_nxt    = TAG_NONE;
      res_nh_nxt     = 1'b0;
    end else if (st == RES_BAD) begin
      // hold all state on a malformed byte
      state_nxt      = state_r;
      seen_nxt       = seen_r;
      major_nxt      = major_r;
      minor_nxt      = minor_r;
      res_status_nxt = RES_BAD;
      res_tag_nxt    = TAG_NONE;
      res_nh_nxt     = 1'b0;
    end else begin
      state_nxt      = ns;
      seen_nxt       = nseen;
      major_nxt      = nmaj;
      minor_nxt      = nmin;
      res_status_nxt = st;
      res_tag_nxt    = tag;
      res_nh_nxt     = nh;
    end
    res_byte_nxt = (res_tag_nxt != TAG_NONE) ? c : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
      state_r     <= ST_METHOD_START;
      seen_r      <= 1'b0;
      major_r     <= '0;
      minor_r     <= '0;
    end else begin
      if (in_tready) begin
        stg_valid_r <= in_tvalid;
      end
      if (advance) begin
        out_valid_r <= 1'b1;
        state_r     <= state_nxt;
        seen_r      <= seen_nxt;
        major_r     <= major_nxt;
        minor_r     <= minor_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tready && in_tvalid) begin
      stg_byte_r <= in_tdata;
      stg_cmd_r  <= in_tuser;
    end
    if (advance) begin
      res_status_r <= res_status_nxt;
      res_tag_r    <= res_tag_nxt;
      res_nh_r     <= res_nh_nxt;
      res_byte_r   <= res_byte_nxt;
    end
  end

  // version fields show the low byte of the counts as they stand after the item
  assign major_wide = WIDE'(major_r);
  assign minor_wide = WIDE'(minor_r);

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, minor_wide[7:0], major_wide[7:0], res_byte_r, res_status_r};
  assign out_tuser  = {res_nh_r, res_tag_r};

`ifndef NO_ASSERTIONS
  a_bad_holds_state: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stg_cmd_r == CMD_CONSUME && res_status_nxt == RES_BAD
    |=> $stable(state_r) && $stable(seen_r) && $stable(major_r) && $stable(minor_r))
    else $error("malformed byte changed parser state");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    advance && stg_cmd_r == CMD_RESTART
    |=> state_r == ST_METHOD_START && !seen_r && major_r == '0 && minor_r == '0)
    else $error("restart did not clear parser state");

  a_new_header_is_name: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_nh_r |-> res_tag_r == TAG_NAME && seen_r)
    else $error("new header flag without header name tag");

  a_good_in_final: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && res_status_r == RES_GOOD |-> state_r == ST_NL3)
    else $error("complete status outside final state");
`endif

endmodule

// ===== bench/http_request_header_parser_checker.sv =====
`timescale 1ns / 100ps
module http_request_header_parser_checker (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tuser,   // [0] cmd
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [31:0] out_tdata,  // [1:0] status, [9:2] byte_out,
                                  // [17:10] version_major, [25:18] version_minor
  input  logic [3:0]  out_tuser,  // [2:0] byte_tag, [3] new_header
  output int          fail_count,
  output int          results_owed
);
  import hrhp_pkg::*;

  localparam int VB = VERSION_BITS_DEF;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;
  localparam logic [7:0] ASCII_TOP  = 8'h80;

  typedef struct packed {
    status_t    status;
    byte_tag_t  tag;
    logic       new_hdr;
    logic [7:0] echo;
    logic [7:0] vmaj;
    logic [7:0] vmin;
  } parse_result_t;

  parse_state_t  pstate;
  logic          hdr_seen;
  logic [VB-1:0] maj_cnt;
  logic [VB-1:0] min_cnt;
  parse_result_t parse_results_due[$];

  initial begin
    fail_count   = 0;
    results_owed = 0;
  end

  function automatic logic ctl_byte(input logic [7:0] c);
    return (c <= CH_CTL_MAX) || (c == CH_DEL);
  endfunction

  // ( ) < > @ , ; : \ " / [ ] ? = { } SP HT
  function automatic logic separator_byte(input logic [7:0] c);
    case (c)
      8'h28, 8'h29, 8'h3c, 8'h3e, 8'h40, 8'h2c, 8'h3b, CH_COLON, 8'h5c, 8'h22,
      CH_SLASH, 8'h5b, 8'h5d, 8'h3f, 8'h3d, 8'h7b, 8'h7d, CH_SP, CH_TAB: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic token_byte(input logic [7:0] c);
    return (c < ASCII_TOP) && !ctl_byte(c) && !separator_byte(c);
  endfunction

  function automatic logic digit_byte(input logic [7:0] c);
    return (c >= DIGIT_ZERO) && (c <= DIGIT_NINE);
  endfunction

  // shift in one decimal digit, pinned at the all-ones count
  function automatic logic [VB-1:0] decimal_push(input logic [VB-1:0] v,
                                                 input logic [7:0] c);
    int n;
    n = int'(v) * 10 + int'(c - DIGIT_ZERO);
    return (n > (1 << VB) - 1) ? {VB{1'b1}} : VB'(n);
  endfunction

  // advance the parser by one item and return the result it produces
  function automatic parse_result_t parse_step(input logic cmd, input logic [7:0] c);
    parse_result_t r;
    parse_state_t  nxt;
    logic [VB-1:0] nmaj;
    logic [VB-1:0] nmin;
    logic          nseen;
    logic          bad;
    r = '0;
    if (cmd == CMD_RESTART) begin
      pstate   = ST_METHOD_START;
      hdr_seen = 1'b0;
      maj_cnt  = '0;
      min_cnt  = '0;
      return r;
    end
    nxt   = pstate;
    nmaj  = maj_cnt;
    nmin  = min_cnt;
    nseen = hdr_seen;
    bad   = 1'b0;
    case (pstate)
      ST_METHOD_START: begin
        if (token_byte(c)) begin
          nxt   = ST_METHOD;
          r.tag = TAG_METHOD;
        end else bad = 1'b1;
      end
      ST_METHOD: begin
        if (c == CH_SP) nxt = ST_URI;
        else if (token_byte(c)) r.tag = TAG_METHOD;
        else bad = 1'b1;
      end
      ST_URI: begin
        if (c == CH_SP) nxt = ST_VER_H;
        else if (ctl_byte(c)) bad = 1'b1;
        else r.tag = TAG_URI;
      end
      ST_VER_H: begin
        if (c == CH_H) nxt = ST_VER_T1; else bad = 1'b1;
      end
      ST_VER_T1: begin
        if (c == CH_T) nxt = ST_VER_T2; else bad = 1'b1;
      end
      ST_VER_T2: begin
        if (c == CH_T) nxt = ST_VER_P; else bad = 1'b1;
      end
      ST_VER_P: begin
        if (c == CH_P) nxt = ST_VER_SLASH; else bad = 1'b1;
      end
      ST_VER_SLASH: begin
        if (c == CH_SLASH) begin
          nmaj = '0;
          nmin = '0;
          nxt  = ST_MAJOR_START;
        end else bad = 1'b1;
      end
      ST_MAJOR_START: begin
        if (digit_byte(c)) begin
          nmaj = decimal_push(maj_cnt, c);
          nxt  = ST_MAJOR;
        end else bad = 1'b1;
      end
      ST_MAJOR: begin
        if (c == CH_DOT) nxt = ST_MINOR_START;
        else if (digit_byte(c)) nmaj = decimal_push(maj_cnt, c);
        else bad = 1'b1;
      end
      ST_MINOR_START: begin
        if (digit_byte(c)) begin
          nmin = decimal_push(min_cnt, c);
          nxt  = ST_MINOR;
        end else bad = 1'b1;
      end
      ST_MINOR: begin
        if (c == CH_CR) nxt = ST_NL1;
        else if (digit_byte(c)) nmin = decimal_push(min_cnt, c);
        else bad = 1'b1;
      end
      ST_NL1: begin
        if (c == CH_LF) nxt = ST_LINE_START; else bad = 1'b1;
      end
      ST_LINE_START: begin
        if (c == CH_CR) nxt = ST_NL3;
        else if (hdr_seen && (c == CH_SP || c == CH_TAB)) nxt = ST_LWS;
        else if (token_byte(c)) begin
          nseen     = 1'b1;
          r.new_hdr = 1'b1;
          r.tag     = TAG_NAME;
          nxt       = ST_NAME;
        end else bad = 1'b1;
      end
      ST_LWS: begin
        if (c == CH_CR) nxt = ST_NL2;
        else if (c == CH_SP || c == CH_TAB) begin
          // hold in folding whitespace
        end else if (ctl_byte(c)) bad = 1'b1;
        else begin
          nxt   = ST_VALUE;
          r.tag = TAG_VALUE;
        end
      end
      ST_NAME: begin
        if (c == CH_COLON) nxt = ST_SPACE_BEFORE;
        else if (token_byte(c)) r.tag = TAG_NAME;
        else bad = 1'b1;
      end
      ST_SPACE_BEFORE: begin
        if (c == CH_SP) nxt = ST_VALUE; else bad = 1'b1;
      end
      ST_VALUE: begin
        if (c == CH_CR) nxt = ST_NL2;
        else if (ctl_byte(c)) bad = 1'b1;
        else r.tag = TAG_VALUE;
      end
      ST_NL2: begin
        if (c == CH_LF) nxt = ST_LINE_START; else bad = 1'b1;
      end
      ST_NL3: begin
        if (c == CH_LF) r.status = RES_GOOD; else bad = 1'b1;
      end
      default: bad = 1'b1;
    endcase
    if (bad) begin
      r.status  = RES_BAD;
      r.tag     = TAG_NONE;
      r.new_hdr = 1'b0;
    end else begin
      pstate   = nxt;
      hdr_seen = nseen;
      maj_cnt  = nmaj;
      min_cnt  = nmin;
    end
    r.echo = (r.tag != TAG_NONE) ? c : 8'h00;
    r.vmaj = maj_cnt[7:0];
    r.vmin = min_cnt[7:0];
    return r;
  endfunction

  task automatic check_field(input string what, input logic [31:0] want,
                             input logic [31:0] got);
    if (got !== want) begin
      $display("%0t: %s mismatch: expected %0d, got %0d", $time, what, want, got);
      fail_count++;
    end
  endtask

  always @(posedge clk) begin : track
    parse_result_t want;
    if (!rst_n) begin
      pstate   = ST_METHOD_START;
      hdr_seen = 1'b0;
      maj_cnt  = '0;
      min_cnt  = '0;
      parse_results_due.delete();
    end else begin
      if (out_tvalid && out_tready) begin
        if (parse_results_due.size() == 0) begin
          $display("%0t: result item with none expected: expected nothing, got tdata %h tuser %h",
                   $time, out_tdata, out_tuser);
          fail_count++;
        end else begin
          want = parse_results_due.pop_front();
          check_field("status", 32'(want.status), 32'(out_tdata[1:0]));
          check_field("byte_out", 32'(want.echo), 32'(out_tdata[9:2]));
          check_field("version_major", 32'(want.vmaj), 32'(out_tdata[17:10]));
          check_field("version_minor", 32'(want.vmin), 32'(out_tdata[25:18]));
          check_field("byte_tag", 32'(want.tag), 32'(out_tuser[2:0]));
          check_field("new_header", 32'(want.new_hdr), 32'(out_tuser[3]));
        end
      end
      if (in_tvalid && in_tready)
        parse_results_due.insert(parse_results_due.size(), parse_step(in_tuser, in_tdata));
    end
    results_owed = parse_results_due.size();
  end

endmodule

// ===== bench/http_request_header_parser_tb.sv =====
`timescale 1ns / 100ps
module http_request_header_parser_tb;
  import hrhp_pkg::*;

  localparam int CYCLE_LIMIT  = 300000;
  localparam int RANDOM_ITEMS = 1650;
  localparam int LONG_HOLD    = 200;
  localparam logic [7:0] DIGIT_ZERO = 8'h30;
  localparam logic [7:0] DIGIT_NINE = 8'h39;

  typedef enum int {SINK_OPEN, SINK_COIN, SINK_MOSTLY, SINK_SPARSE} sink_mode_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = CMD_CONSUME;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [31:0] out_tdata;
  logic [3:0]  out_tuser;

  int fail_count;
  int results_owed;
  int items_sent = 0;
  int burst_left = 0;
  int noise_pct = 0;
  int cycles_run = 0;
  logic [8:0] request_bytes[$];  // {cmd, data_byte}
  string token_chars =
    "!#$%&'*+-.^_|~0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz";

  always #2 clk = ~clk;

  http_request_header_parser i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  http_request_header_parser_checker i_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_tvalid    (in_tvalid),
    .in_tready    (in_tready),
    .in_tdata     (in_tdata),
    .in_tuser     (in_tuser),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_tdata    (out_tdata),
    .out_tuser    (out_tuser),
    .fail_count   (fail_count),
    .results_owed (results_owed)
  );

  // offer one item in bursts, with random gaps between bursts
  task automatic push_item(input logic [8:0] item);
    int gap;
    if (burst_left == 0) begin
      in_tvalid = 1'b0;
      gap = ($urandom_range(0, 7) == 0) ? $urandom_range(8, 20) : $urandom_range(0, 3);
      repeat (gap) @(negedge clk);
      burst_left = $urandom_range(1, 60);
    end
    in_tvalid = 1'b1;
    in_tuser  = item[8];
    in_tdata  = item[7:0];
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    @(negedge clk);
    burst_left--;
    items_sent++;
  endtask

  // stop offering until every result is back, then let the pipe settle
  task automatic drain();
    in_tvalid = 1'b0;
    while (results_owed != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic queue_byte(input logic [8:0] item);
    request_bytes.insert(request_bytes.size(), item);
  endtask

  task automatic put(input logic [7:0] b);
    if (noise_pct != 0 && $urandom_range(1, 100) <= noise_pct)
      queue_byte({CMD_CONSUME, 8'($urandom_range(0, 255))});
    else
      queue_byte({CMD_CONSUME, b});
  endtask

  task automatic put_token(input int n);
    repeat (n) put(token_chars[$urandom_range(0, token_chars.len() - 1)]);
  endtask

  task automatic put_digits(input int n);
    repeat (n) put(DIGIT_ZERO + 8'($urandom_range(0, 9)));
  endtask

  task automatic put_value(input int n);
    repeat (n)
      put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                       : 8'($urandom_range(32, 126)));
  endtask

  initial begin : watchdog
    while (cycles_run < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles_run++;
    end
    $display("tb: failure");
    $finish;
  end

  initial begin : result_sink
    sink_mode_t mode;
    int         span;
    bit         held_long;
    held_long = 1'b0;
    wait (rst_n);
    forever begin
      mode = sink_mode_t'($urandom_range(0, 3));
      span = $urandom_range(16, 120);
      if (!held_long && items_sent > 400) begin
        // long hold-off: let the block fill and back up the sender
        out_tready = 1'b0;
        repeat (LONG_HOLD) @(negedge clk);
        held_long = 1'b1;
      end else begin
        repeat (span) begin
          case (mode)
            SINK_OPEN:   out_tready = 1'b1;
            SINK_COIN:   out_tready = ($urandom_range(0, 1) == 1);
            SINK_MOSTLY: out_tready = ($urandom_range(0, 7) != 0);
            default:     out_tready = ($urandom_range(0, 3) == 0);
          endcase
          @(negedge clk);
        end
      end
    end
  end

  initial begin : stimulus
    logic [8:0] directed_seq [0:24];
    string      version_tag;
    int         random_start;
    bit         mid_pause_done;
    directed_seq = '{
      {CMD_RESTART, 8'ha5},
      {CMD_CONSUME, 8'h00},       // control byte where a method starts
      {CMD_CONSUME, 8'hff},       // non-ASCII where a method starts
      {CMD_CONSUME, 8'h47},
      {CMD_CONSUME, CH_SP},
      {CMD_CONSUME, 8'hff},       // non-ASCII is fine in the URI
      {CMD_CONSUME, 8'h80},
      {CMD_CONSUME, CH_SP},
      {CMD_CONSUME, CH_H},
      {CMD_CONSUME, CH_T},
      {CMD_CONSUME, CH_T},
      {CMD_CONSUME, CH_P},
      {CMD_CONSUME, CH_SLASH},
      {CMD_CONSUME, DIGIT_NINE},
      {CMD_CONSUME, DIGIT_NINE},
      {CMD_CONSUME, DIGIT_NINE},  // major pins at its ceiling
      {CMD_CONSUME, CH_DOT},
      {CMD_CONSUME, DIGIT_ZERO},
      {CMD_CONSUME, CH_CR},
      {CMD_CONSUME, CH_LF},
      {CMD_CONSUME, CH_SP},       // folding before any header is refused
      {CMD_CONSUME, CH_CR},
      {CMD_CONSUME, CH_LF},
      {CMD_CONSUME, CH_LF},       // complete again after the end
      {CMD_CONSUME, CH_DEL}       // anything else after the end is refused
    };
    version_tag = "HTTP/";
    repeat (12) @(negedge clk);
    rst_n = 1'b1;

    foreach (directed_seq[i]) push_item(directed_seq[i]);
    drain();

    random_start   = items_sent;
    mid_pause_done = 1'b0;
    while (items_sent - random_start < RANDOM_ITEMS) begin
      request_bytes.delete();
      if ($urandom_range(0, 19) == 0) begin
        // raw junk with the odd restart mixed in
        noise_pct = 0;
        repeat ($urandom_range(8, 30)) begin
          if ($urandom_range(0, 15) == 0)
            queue_byte({CMD_RESTART, 8'($urandom_range(0, 255))});
          else
            put(8'($urandom_range(0, 255)));
        end
      end else begin
        noise_pct = ($urandom_range(0, 9) < 7) ? 0 : $urandom_range(2, 10);
        queue_byte({CMD_RESTART, 8'($urandom_range(0, 255))});
        put_token($urandom_range(1, 7));
        put(CH_SP);
        repeat ($urandom_range(1, 10))
          put(($urandom_range(0, 3) == 0) ? 8'($urandom_range(128, 255))
                                           : 8'($urandom_range(33, 126)));
        put(CH_SP);
        for (int k = 0; k < version_tag.len(); k++) put(version_tag[k]);
        put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2));
        put(CH_DOT);
        put_digits(($urandom_range(0, 7) == 0) ? $urandom_range(3, 5) : $urandom_range(1, 2));
        put(CH_CR);
        put(CH_LF);
        repeat ($urandom_range(0, 4)) begin
          put_token($urandom_range(1, 8));
          put(CH_COLON);
          put(CH_SP);
          put_value($urandom_range(0, 10));
          put(CH_CR);
          put(CH_LF);
          if ($urandom_range(0, 3) == 0) begin
            // folded continuation of the header just sent
            repeat ($urandom_range(1, 3)) put($urandom_range(0, 1) ? CH_SP : CH_TAB);
            put_value($urandom_range(0, 6));
            put(CH_CR);
            put(CH_LF);
          end
        end
        put(CH_CR);
        put(CH_LF);
        if ($urandom_range(0, 3) == 0) begin
          put(CH_LF);
          put(8'($urandom_range(0, 255)));
        end
      end
      if (!mid_pause_done && items_sent - random_start > RANDOM_ITEMS / 2) begin
        drain();
        mid_pause_done = 1'b1;
      end
      foreach (request_bytes[i]) push_item(request_bytes[i]);
    end

    drain();
    if (fail_count == 0 && results_owed == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

endmodule
